// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define BLI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent holds.
`define BLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bli_pkg.sv =====
`default_nettype none

package bli_pkg;

  localparam int CODE_W = 12;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] BLINK_TICKS = 16'd500;

  // Indicator levels as shown on the result channel.
  typedef enum logic [1:0] {
    LVL_RED    = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_GREEN  = 2'd2,
    LVL_CRIT   = 2'd3
  } lvl_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_CRIT_ENTER   = 3'd0,
    CFG_CRIT_EXIT    = 3'd1,
    CFG_YELLOW_ENTER = 3'd2,
    CFG_YELLOW_EXIT  = 3'd3,
    CFG_GREEN_ENTER  = 3'd4,
    CFG_GREEN_EXIT   = 3'd5,
    CFG_DEBOUNCE     = 3'd6,
    CFG_UPDATE       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] crit_enter;
    logic [CODE_W-1:0] crit_exit;
    logic [CODE_W-1:0] yellow_enter;
    logic [CODE_W-1:0] yellow_exit;
    logic [CODE_W-1:0] green_enter;
    logic [CODE_W-1:0] green_exit;
    logic [CNT_W-1:0]  debounce_ticks;
    logic [CNT_W-1:0]  update_ticks;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic green_led;
    logic red_led;
    logic power_led;
    lvl_t level;
    logic powered;
  } res_t;

  // Counter that stops at its maximum instead of wrapping.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bli_cfg.sv =====
`default_nettype none

module bli_cfg import bli_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; each register keeps only its own width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CRIT_ENTER:   cfg_nxt.crit_enter     = cfg_wdata[CODE_W-1:0];
        CFG_CRIT_EXIT:    cfg_nxt.crit_exit      = cfg_wdata[CODE_W-1:0];
        CFG_YELLOW_ENTER: cfg_nxt.yellow_enter   = cfg_wdata[CODE_W-1:0];
        CFG_YELLOW_EXIT:  cfg_nxt.yellow_exit    = cfg_wdata[CODE_W-1:0];
        CFG_GREEN_ENTER:  cfg_nxt.green_enter    = cfg_wdata[CODE_W-1:0];
        CFG_GREEN_EXIT:   cfg_nxt.green_exit     = cfg_wdata[CODE_W-1:0];
        CFG_DEBOUNCE:     cfg_nxt.debounce_ticks = cfg_wdata[CNT_W-1:0];
        CFG_UPDATE:       cfg_nxt.update_ticks   = cfg_wdata[CNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // Reset loads the default thresholds and intervals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crit_enter     <= 12'd2517;
      cfg_r.crit_exit      <= 12'd2632;
      cfg_r.yellow_enter   <= 12'd2747;
      cfg_r.yellow_exit    <= 12'd2690;
      cfg_r.green_enter    <= 12'd3265;
      cfg_r.green_exit     <= 12'd3208;
      cfg_r.debounce_ticks <= 16'd50;
      cfg_r.update_ticks   <= 16'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/bli_core.sv =====
`default_nettype none

module bli_core import bli_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              button_level,
  input  wire logic              sample_valid,
  input  wire logic [CODE_W-1:0] sample,
  input  wire cfg_t              cfg,
  output res_t                   res
);

  logic              prev_seen_r,  prev_seen_nxt;
  logic              deb_level_r,  deb_level_nxt;
  logic [CNT_W-1:0]  stable_cnt_r, stable_cnt_nxt;
  logic              power_on_r,   power_on_nxt;
  logic [CNT_W-1:0]  since_upd_r,  since_upd_nxt;
  logic [CNT_W-1:0]  since_blink_r, since_blink_nxt;
  logic              blink_r,      blink_nxt;
  lvl_t              level_r,      level_nxt;
  logic [CODE_W-1:0] held_r,       held_nxt;
  logic              fresh_r,      fresh_nxt;
  logic              green_r,      green_nxt;
  logic              red_r,        red_nxt;
  logic              pwr_drv_r,    pwr_drv_nxt;

  logic toggle;
  logic update;

  // One tick of the model: sample capture, debounce, timers, level update.
  always_comb begin
    held_nxt  = sample_valid ? sample : held_r;
    fresh_nxt = sample_valid | fresh_r;

    // Debounce: count ticks at a steady level, take it once exceeded.
    stable_cnt_nxt = (button_level != prev_seen_r) ? '0 : sat_inc(stable_cnt_r);
    prev_seen_nxt  = button_level;
    deb_level_nxt  = deb_level_r;
    toggle         = 1'b0;
    if ((stable_cnt_nxt > cfg.debounce_ticks) && (button_level != deb_level_r)) begin
      deb_level_nxt = button_level;
      toggle        = button_level;
    end

    power_on_nxt = power_on_r ^ toggle;
    green_nxt    = green_r;
    red_nxt      = red_r;
    pwr_drv_nxt  = pwr_drv_r;
    if (toggle) begin
      if (!power_on_nxt) begin
        green_nxt   = 1'b0;
        red_nxt     = 1'b0;
        pwr_drv_nxt = 1'b0;
      end else begin
        pwr_drv_nxt = 1'b1;
      end
    end

    since_upd_nxt   = sat_inc(since_upd_r);
    since_blink_nxt = sat_inc(since_blink_r);
    blink_nxt       = blink_r;
    level_nxt       = level_r;

    // Periodic update consumes a fresh sample through the hysteresis levels.
    update = power_on_nxt && (since_upd_nxt >= cfg.update_ticks);
    if (update) begin
      since_upd_nxt = '0;
      if (fresh_nxt) begin
        fresh_nxt = 1'b0;
        if (held_nxt < cfg.crit_enter) begin
          level_nxt = LVL_CRIT;
        end else if ((level_r == LVL_CRIT) && (held_nxt >= cfg.crit_exit)) begin
          level_nxt = LVL_RED;
        end else begin
          case (level_r)
            LVL_RED: begin
              if (held_nxt >= cfg.yellow_enter) level_nxt = LVL_YELLOW;
            end
            LVL_YELLOW: begin
              if (held_nxt >= cfg.green_enter) level_nxt = LVL_GREEN;
              else if (held_nxt < cfg.yellow_exit) level_nxt = LVL_RED;
            end
            LVL_GREEN: begin
              if (held_nxt < cfg.green_exit) level_nxt = LVL_YELLOW;
            end
            default: level_nxt = level_r;
          endcase
        end

        case (level_nxt)
          LVL_CRIT: begin
            if (since_blink_nxt >= BLINK_TICKS) begin
              since_blink_nxt = '0;
              blink_nxt       = ~blink_r;
            end
            green_nxt = 1'b0;
            red_nxt   = blink_nxt;
          end
          LVL_GREEN: begin
            green_nxt = 1'b1;
            red_nxt   = 1'b0;
          end
          LVL_YELLOW: begin
            green_nxt = 1'b1;
            red_nxt   = 1'b1;
          end
          default: begin
            green_nxt = 1'b0;
            red_nxt   = 1'b1;
          end
        endcase
      end
    end

    res.green_led = green_nxt;
    res.red_led   = red_nxt;
    res.power_led = pwr_drv_nxt;
    res.level     = level_nxt;
    res.powered   = power_on_nxt;
  end

  // State advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seen_r   <= 1'b0;
      deb_level_r   <= 1'b0;
      stable_cnt_r  <= '0;
      power_on_r    <= 1'b0;
      since_upd_r   <= '0;
      since_blink_r <= '0;
      blink_r       <= 1'b0;
      level_r       <= LVL_RED;
      held_r        <= '0;
      fresh_r       <= 1'b0;
      green_r       <= 1'b0;
      red_r         <= 1'b0;
      pwr_drv_r     <= 1'b0;
    end else if (accept) begin
      prev_seen_r   <= prev_seen_nxt;
      deb_level_r   <= deb_level_nxt;
      stable_cnt_r  <= stable_cnt_nxt;
      power_on_r    <= power_on_nxt;
      since_upd_r   <= since_upd_nxt;
      since_blink_r <= since_blink_nxt;
      blink_r       <= blink_nxt;
      level_r       <= level_nxt;
      held_r        <= held_nxt;
      fresh_r       <= fresh_nxt;
      green_r       <= green_nxt;
      red_r         <= red_nxt;
      pwr_drv_r     <= pwr_drv_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bli_obuf.sv =====
`default_nettype none

module bli_obuf import bli_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t din,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      dout
);

  logic out_valid_r,  out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r,   out_data_nxt;
  res_t skid_data_r,  skid_data_nxt;
  logic out_take;

  assign out_take = out_valid_r & ~out_stall;

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_take) begin
        skid_data_nxt  = din;
        skid_valid_nxt = 1'b1;
      end else begin
        out_data_nxt  = din;
        out_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign dout      = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/battery_level_indicator.sv =====
// Battery level indicator with a debounced power button.
// Input channel (in_valid / in_stall): one beat per millisecond tick with the
// raw button level and an optional 12-bit battery sample.
// Result channel (out_valid / out_stall): exactly one beat per input beat with
// the LED drives, the indicator level and the power state.
// Configuration port: cfg_we writes cfg_wdata into register cfg_index; write
// only while no beat is in flight.
// A beat's result is registered in the output register, or in the skid entry
// while out_stall holds. Throughput: one beat per cycle while in_stall is low;
// each tick's state update is one pass of compares and saturating 16-bit counters.
// Reset: all state clears, the registers reload their defaults (power off,
// level red, LEDs dark) and no result is pending.
// Stall: while out_stall holds, one more beat is taken into a skid entry,
// then in_stall rises until the output register drains.
`default_nettype none

module battery_level_indicator import bli_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_button_level,
  input  wire logic              in_sample_valid,
  input  wire logic [CODE_W-1:0] in_sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_green_led,
  output logic                   out_red_led,
  output logic                   out_power_led,
  output logic [1:0]             out_level,
  output logic                   out_powered,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t res;
  res_t res_out;
  logic full;
  logic accept;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  bli_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bli_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .button_level (in_button_level),
    .sample_valid (in_sample_valid),
    .sample       (in_sample),
    .cfg          (cfg),
    .res          (res)
  );

  bli_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  // Result fields onto their ports.
  assign out_green_led = res_out.green_led;
  assign out_red_led   = res_out.red_led;
  assign out_power_led = res_out.power_led;
  assign out_level     = res_out.level;
  assign out_powered   = res_out.powered;

endmodule

`default_nettype wire

// ===== rtl/bli_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module bli_checker import bli_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_green_led,
  input wire logic              out_red_led,
  input wire logic              out_power_led,
  input wire logic [1:0]        out_level,
  input wire logic              out_powered
);

  // The power LED follows the power state on every result beat.
  `BLI_ASSERT_IMPL(a_power_led, out_valid, out_power_led == out_powered,
                   "power LED mismatch")

  // With power off, both indicator LEDs are dark.
  `BLI_ASSERT_IMPL(a_dark_off, out_valid && !out_powered,
                   !out_green_led && !out_red_led, "LED lit while off")

  // The critical level never shows green.
  `BLI_ASSERT_IMPL(a_crit_green, out_valid && (out_level == LVL_CRIT), !out_green_led,
                   "green while critical")

  // Input back-pressure only arises with a result waiting.
  `BLI_ASSERT_IMPL(a_stall_cause, in_stall, out_valid, "input stalled with empty output")

  // A stalled result beat stays valid, with its level and power state unchanged.
  `BLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_level) && $stable(out_powered),
                   "stalled result changed")

endmodule

bind battery_level_indicator bli_checker u_bli_checker (.*);

`default_nettype wire
